// ===== design/lwf_pkg.sv =====
// ----------------------------------------------------------------------------
// Line and wall follow steering package
// Shared types, register indexes and the speed table.
// ----------------------------------------------------------------------------
`default_nettype none
package lwf_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;
  localparam int GainW    = 12;

  typedef enum logic [1:0] {
    MODE_LINE  = 2'd0,
    MODE_SHARP = 2'd1,
    MODE_WALL  = 2'd2,
    MODE_HOLD  = 2'd3
  } lwf_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LINE_KP    = 3'd0,
    REG_LINE_KD    = 3'd1,
    REG_WALL_KP    = 3'd2,
    REG_WALL_KD    = 3'd3,
    REG_LINE_SPEED = 3'd4,
    REG_WALL_SPEED = 3'd5,
    REG_SHARP_THR  = 3'd6,
    REG_WALL_LIMIT = 3'd7
  } lwf_reg_e;

  // Base speed table in Q8, 33 points over the 10-bit center level.
  function automatic logic signed [12:0] speed_rom(input logic [5:0] idx);
    logic signed [12:0] r;
    case (idx)
      6'd0:  r = -13'sd980;
      6'd1:  r = -13'sd930;
      6'd2:  r = -13'sd878;
      6'd3:  r = -13'sd823;
      6'd4:  r = -13'sd765;
      6'd5:  r = -13'sd705;
      6'd6:  r = -13'sd643;
      6'd7:  r = -13'sd577;
      6'd8:  r = -13'sd508;
      6'd9:  r = -13'sd436;
      6'd10: r = -13'sd361;
      6'd11: r = -13'sd282;
      6'd12: r = -13'sd199;
      6'd13: r = -13'sd113;
      6'd14: r = -13'sd22;
      6'd15: r = 13'sd73;
      6'd16: r = 13'sd172;
      6'd17: r = 13'sd276;
      6'd18: r = 13'sd384;
      6'd19: r = 13'sd498;
      6'd20: r = 13'sd617;
      6'd21: r = 13'sd742;
      6'd22: r = 13'sd872;
      6'd23: r = 13'sd1009;
      6'd24: r = 13'sd1152;
      6'd25: r = 13'sd1302;
      6'd26: r = 13'sd1458;
      6'd27: r = 13'sd1622;
      6'd28: r = 13'sd1794;
      6'd29: r = 13'sd1974;
      6'd30: r = 13'sd2162;
      6'd31: r = 13'sd2359;
      6'd32: r = 13'sd2565;
      default: r = 13'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/lwf_intf.sv =====
// ----------------------------------------------------------------------------
// Line and wall follow steering channels
// Valid/ready channels for sensor items, drive items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface lwf_in_if #(parameter int LEVEL_BITS = 10);
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] left_level;
  logic [LEVEL_BITS-1:0] center_level;
  logic [LEVEL_BITS-1:0] right_level;
  logic [5:0]            left_distance;
  logic [5:0]            center_distance;
  logic [5:0]            right_distance;
  modport source (output valid, left_level, center_level, right_level,
                  left_distance, center_distance, right_distance, input ready);
  modport sink (input valid, left_level, center_level, right_level,
                left_distance, center_distance, right_distance, output ready);
endinterface

interface lwf_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] left_drive;
  logic signed [8:0] right_drive;
  logic [1:0]        steer_mode;
  modport source (output valid, left_drive, right_drive, steer_mode, input ready);
  modport sink (input valid, left_drive, right_drive, steer_mode, output ready);
endinterface

interface lwf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/lwf_serdiv.sv =====
// ----------------------------------------------------------------------------
// Line and wall follow serial divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lwf_serdiv #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);
  localparam int CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], fits};
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;
endmodule
`default_nettype wire

// ===== design/line_and_wall_follow_steering_core.sv =====
// ----------------------------------------------------------------------------
// Line and wall follow steering core
// PD steering from line sensors or wall distances, one item at a time.
// Line follow runs the serial divider, a handoff when it is done, the
// shift-add multiply steps and a finish state; wall follow runs the multiply
// steps and the finish; sharp turn and hold go straight to the finish and keep
// the held drives. A new item can be taken while the output item is presented,
// and the finish waits while the previous output item stalls.
// Reset restores default registers, clears the error history and the held drives.
// ----------------------------------------------------------------------------
`default_nettype none
module line_and_wall_follow_steering_core #(
  parameter int LEVEL_BITS   = 10,
  parameter int MAX_DISTANCE = 50
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  lwf_cfg_if.sink  cfg_i,
  lwf_in_if.sink   in_i,
  lwf_out_if.source out_o
);
  import lwf_pkg::*;

  localparam int SumW = LEVEL_BITS + 2;
  localparam int NumW = LEVEL_BITS + 7;
  localparam int AccW = 24;
  localparam int W    = 26;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q;

  logic [GainW-1:0] line_kp_q, line_kd_q, wall_kp_q, wall_kd_q;
  logic [5:0]       line_speed_q;
  logic [7:0]       wall_speed_q, wall_limit_q;
  logic [9:0]       sharp_thr_q;

  logic signed [7:0] line_prev_q, line_e_q;
  logic signed [6:0] wall_prev_q, wall_e_q;
  logic              neg_q;
  lwf_mode_e         mode_q;
  logic signed [12:0] spd_q;
  logic [17:0]        base_q;

  logic signed [AccW-1:0] acc_q, a_q, b_q;
  logic [GainW-1:0]       ga_q, gb_q;
  logic [3:0]             cnt_q;

  logic              out_valid_q;
  logic signed [8:0] left_q, right_q;
  lwf_mode_e         out_mode_q;

  logic in_acc, out_free;
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  // Accept-time decode.
  logic [SumW-1:0]         sum;
  logic [LEVEL_BITS-1:0]   mag;
  logic [NumW-1:0]         num;
  logic                    sharp, nothing, lr_neg;
  logic [11:0]             vl12, vc12, vr12, thr12;
  logic signed [6:0]       we;
  logic signed [7:0]       wde;
  logic [7:0]              max8;

  assign sum   = SumW'(in_i.left_level) + SumW'(in_i.center_level)
               + SumW'(in_i.right_level);
  assign lr_neg = in_i.left_level > in_i.right_level;
  assign mag   = lr_neg ? (in_i.left_level - in_i.right_level)
                        : (in_i.right_level - in_i.left_level);
  assign num   = (NumW'(mag) << 6) + (NumW'(mag) << 5) + (NumW'(mag) << 2);
  assign vl12  = 12'(in_i.left_level);
  assign vc12  = 12'(in_i.center_level);
  assign vr12  = 12'(in_i.right_level);
  assign thr12 = {2'b00, sharp_thr_q};
  assign sharp = (vc12 > thr12) && ((vr12 > thr12) || (vl12 > thr12));
  assign max8  = 8'(MAX_DISTANCE);
  assign nothing = ({2'b00, in_i.left_distance} == max8)
                && ({2'b00, in_i.center_distance} == max8)
                && ({2'b00, in_i.right_distance} == max8);
  assign we    = $signed({1'b0, in_i.left_distance}) - $signed({1'b0, in_i.right_distance});
  assign wde   = 8'(we) - 8'(wall_prev_q);

  // Speed table lookup with interpolation.
  logic [9:0] c10;
  generate
    if (LEVEL_BITS >= 10) begin : g_scale_dn
      assign c10 = in_i.center_level[LEVEL_BITS-1 -: 10];
    end else begin : g_scale_up
      assign c10 = {in_i.center_level, (10-LEVEL_BITS)'(0)};
    end
  endgenerate

  logic signed [12:0] r0, r1, rdiff, spd_d;
  logic [12:0]        prod;
  assign r0    = speed_rom({1'b0, c10[9:5]});
  assign r1    = speed_rom({1'b0, c10[9:5]} + 6'd1);
  assign rdiff = r1 - r0;
  assign prod  = 13'(rdiff[7:0]) * 13'(c10[4:0]);
  assign spd_d = r0 + $signed({5'b00000, prod[12:5]});

  // Divider.
  logic            div_done;
  logic [NumW-1:0] quot;
  lwf_serdiv #(.NUM_W(NumW), .DEN_W(SumW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && (sum != '0) && !sharp),
    .num_i   (num),
    .den_i   (sum),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  logic signed [7:0]  le;
  logic signed [8:0]  lde;
  logic [11:0]        spd_pos;
  assign le      = neg_q ? -$signed({1'b0, quot[6:0]}) : $signed({1'b0, quot[6:0]});
  assign lde     = 9'(le) - 9'(line_prev_q);
  assign spd_pos = 12'(spd_q + 13'sd1024);

  function automatic logic signed [W-1:0] trunc8(input logic signed [W-1:0] v);
    logic signed [W-1:0] m;
    m = v[W-1] ? -v : v;
    m = m >>> 8;
    return v[W-1] ? -m : m;
  endfunction

  function automatic logic signed [8:0] sat9(input logic signed [W-1:0] v);
    logic signed [8:0] r;
    if (v > W'(255)) r = 9'sd255;
    else if (v < -W'(255)) r = -9'sd255;
    else r = v[8:0];
    return r;
  endfunction

  logic signed [W-1:0] acc_w, corr, base_w, l_line, r_line;
  logic signed [W-1:0] lim, sp, cl, l_wall, r_wall;
  assign acc_w  = W'(acc_q);
  assign corr   = trunc8(acc_w);
  assign base_w = $signed({8'b0, base_q});
  assign l_line = trunc8(base_w - (corr <<< 8));
  assign r_line = trunc8(base_w + (corr <<< 8));
  assign lim    = $signed({10'b0, wall_limit_q, 8'b0});
  assign sp     = $signed({10'b0, wall_speed_q, 8'b0});
  assign cl     = (acc_w > lim) ? lim : ((acc_w < -lim) ? -lim : acc_w);
  assign l_wall = trunc8(sp + cl);
  assign r_wall = trunc8(sp - cl);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_kp_q    <= 12'd768;
      line_kd_q    <= 12'd205;
      wall_kp_q    <= 12'd1024;
      wall_kd_q    <= 12'd256;
      line_speed_q <= 6'd10;
      wall_speed_q <= 8'd40;
      sharp_thr_q  <= 10'd970;
      wall_limit_q <= 8'd40;
    end else if (cfg_i.valid) begin
      unique case (lwf_reg_e'(cfg_i.index))
        REG_LINE_KP:    line_kp_q    <= cfg_i.data;
        REG_LINE_KD:    line_kd_q    <= cfg_i.data;
        REG_WALL_KP:    wall_kp_q    <= cfg_i.data;
        REG_WALL_KD:    wall_kd_q    <= cfg_i.data;
        REG_LINE_SPEED: line_speed_q <= cfg_i.data[5:0];
        REG_WALL_SPEED: wall_speed_q <= cfg_i.data[7:0];
        REG_SHARP_THR:  sharp_thr_q  <= cfg_i.data[9:0];
        REG_WALL_LIMIT: wall_limit_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      line_prev_q <= '0;
      wall_prev_q <= '0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      out_mode_q  <= MODE_LINE;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != ST_FIN)) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (sum != '0) begin
              state_q <= sharp ? ST_FIN : ST_DIV;
            end else if (!nothing) begin
              state_q <= ST_MUL;
            end else begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_DIV: begin
          if (div_done) state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (cnt_q == 4'd11) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            out_mode_q  <= mode_q;
            if (mode_q == MODE_LINE) begin
              line_prev_q <= line_e_q;
              left_q      <= sat9(l_line);
              right_q     <= sat9(r_line);
            end else if (mode_q == MODE_WALL) begin
              wall_prev_q <= wall_e_q;
              left_q      <= sat9(l_wall);
              right_q     <= sat9(r_wall);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      neg_q    <= lr_neg;
      spd_q    <= spd_d;
      wall_e_q <= we;
      acc_q    <= '0;
      cnt_q    <= '0;
      a_q      <= AccW'(we);
      b_q      <= AccW'(wde);
      ga_q     <= wall_kp_q;
      gb_q     <= wall_kd_q;
      if (sum != '0) mode_q <= sharp ? MODE_SHARP : MODE_LINE;
      else mode_q <= nothing ? MODE_HOLD : MODE_WALL;
    end else if (state_q == ST_DIV && div_done) begin
      line_e_q <= le;
      base_q   <= 18'(line_speed_q) * 18'(spd_pos);
      a_q      <= AccW'(le);
      b_q      <= AccW'(lde);
      ga_q     <= line_kp_q;
      gb_q     <= line_kd_q;
    end else if (state_q == ST_MUL) begin
      acc_q <= acc_q + (ga_q[0] ? a_q : '0) + (gb_q[0] ? b_q : '0);
      a_q   <= a_q <<< 1;
      b_q   <= b_q <<< 1;
      ga_q  <= ga_q >> 1;
      gb_q  <= gb_q >> 1;
      cnt_q <= cnt_q + 4'd1;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.left_drive  = left_q;
  assign out_o.right_drive = right_q;
  assign out_o.steer_mode  = out_mode_q;
endmodule
`default_nettype wire

// ===== design/lwf_checker.sv =====
// ----------------------------------------------------------------------------
// Line and wall follow steering checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none
module lwf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [8:0] left_drive,
  input wire logic [8:0] right_drive,
  input wire logic [1:0] steer_mode
);
  // A waiting item holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(left_drive)
      && $stable(right_drive) && $stable(steer_mode))
    else $error("output item changed while stalled");

  // Only one item is worked on at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // Drives saturate at 255 in magnitude.
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (left_drive != 9'h100) && (right_drive != 9'h100))
    else $error("drive out of range");
endmodule

bind line_and_wall_follow_steering_core lwf_checker u_lwf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .left_drive  (out_o.left_drive),
  .right_drive (out_o.right_drive),
  .steer_mode  (out_o.steer_mode)
);
`default_nettype wire
